@@ rtl/sorted_set_engine_top_macros.svh @@
// assertion macros for the sorted set engine
// used by the sequencer; expects clk and rst in scope
`ifndef SORTED_SET_ENGINE_TOP_MACROS_SVH
`define SORTED_SET_ENGINE_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define SSE_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sse check failed");

// antecedent implies consequent in the same cycle
`define SSE_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sse implication failed");

// antecedent implies consequent in the next cycle
`define SSE_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sse next-cycle check failed");

`endif

@@ rtl/sse_pkg.sv @@
// shared types and constants for the sorted set engine
// no dependencies
`default_nettype none

package sse_pkg;

  localparam int CAPACITY  = 64;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 32;
  localparam int OUT_CNT_W = 7;
  localparam int CMD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    key_t              wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                 found;
    logic                 pred_valid;
    key_t                 pred_value;
    logic                 succ_valid;
    key_t                 succ_value;
    logic [OUT_CNT_W-1:0] stored_count;
    logic                 full_error;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/sorted_set_engine_top.sv @@
// sorted set engine: keeps up to CAPACITY distinct signed keys in ascending order.
// Request channel (req_valid/req_ready, command, key): one search, insert or
// remove per request; req_ready is high only while the sequencer is idle.
// Response channel (rsp_valid/rsp_ready): found flag, nearest smaller and larger
// stored keys with valid flags, count after the operation, and full_error for a
// refused insert into a full store.
// Sequence: the scan reads the stored keys in order through the single read port,
// a read state and a compare state per key, stopping at the first key above the
// request key, then a decide state. An insert of a new key at position p moves
// count-p entries, each by a read state and a write state, then writes the key;
// a remove moves count-p-1 entries the same way. req_ready comes back with
// rsp_valid, so a new request is taken only once the last result has been loaded.
// A finished response waits in the output register; the next request is taken
// while it waits, and its result holds in the sequencer until the register is free.
// Reset (rst, synchronous) empties the store and drops any pending response;
// memory contents are not cleared, entries past the count are never used.
// depends on sse_pkg, sse_key_store and sse_seq
`default_nettype none

module sorted_set_engine_top
  import sse_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire logic [CMD_W-1:0]     command,
  input  wire key_t                 key,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output logic                      found,
  output logic                      pred_valid,
  output key_t                      pred_value,
  output logic                      succ_valid,
  output key_t                      succ_value,
  output logic [OUT_CNT_W-1:0]      stored_count,
  output logic                      full_error
);

  mem_req_t mem_req;
  key_t     rdata;
  logic     done;
  logic     rsp_load;
  rsp_t     result;
  rsp_t     rsp_q;

  sse_key_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  sse_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .command   (command),
    .key       (key),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .done      (done),
    .rsp_load  (rsp_load),
    .result    (result)
  );

  assign rsp_load = done && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (rsp_load) begin
      rsp_q <= result;
    end
  end

  assign found        = rsp_q.found;
  assign pred_valid   = rsp_q.pred_valid;
  assign pred_value   = rsp_q.pred_value;
  assign succ_valid   = rsp_q.succ_valid;
  assign succ_value   = rsp_q.succ_value;
  assign stored_count = rsp_q.stored_count;
  assign full_error   = rsp_q.full_error;

endmodule

`default_nettype wire

@@ rtl/sse_key_store.sv @@
// key memory: one write port, one read port with registered read data
// depends on sse_pkg
`default_nettype none

module sse_key_store
  import sse_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output key_t          rdata
);

  key_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

@@ rtl/sse_seq.sv @@
// sequencer: linear scan with one shared compare, then entry shifting
// depends on sse_pkg, sse_key_store ports and the assertion macros
`default_nettype none
`include "sorted_set_engine_top_macros.svh"

module sse_seq
  import sse_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire logic [CMD_W-1:0] command,
  input  wire key_t             key,
  output mem_req_t              mem_req,
  input  wire key_t             rdata,
  output logic                  done,
  input  wire logic             rsp_load,
  output rsp_t                  result
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SCAN_RD  = 9'b000000010,
    S_SCAN_CMP = 9'b000000100,
    S_DECIDE   = 9'b000001000,
    S_INS_RD   = 9'b000010000,
    S_INS_WR   = 9'b000100000,
    S_REM_RD   = 9'b001000000,
    S_REM_WR   = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] pos, pos_next;
  logic [CMD_W-1:0] cmd, cmd_next;
  key_t             key_r, key_r_next;
  logic             found, found_next;
  logic             pred_ok, pred_ok_next;
  key_t             pred, pred_next;
  logic             succ_ok, succ_ok_next;
  key_t             succ, succ_next;
  logic             full_err, full_err_next;
  logic [CNT_W-1:0] idx_inc, idx_dec;

  assign idx_inc = idx + CNT_W'(1);
  assign idx_dec = idx - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx      <= idx_next;
    pos      <= pos_next;
    cmd      <= cmd_next;
    key_r    <= key_r_next;
    found    <= found_next;
    pred_ok  <= pred_ok_next;
    pred     <= pred_next;
    succ_ok  <= succ_ok_next;
    succ     <= succ_next;
    full_err <= full_err_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    pos_next      = pos;
    cmd_next      = cmd;
    key_r_next    = key_r;
    found_next    = found;
    pred_ok_next  = pred_ok;
    pred_next     = pred;
    succ_ok_next  = succ_ok;
    succ_next     = succ;
    full_err_next = full_err;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx[ADDR_W-1:0];
    mem_req.wdata = rdata;
    mem_req.raddr = idx[ADDR_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd_next      = command;
          key_r_next    = key;
          idx_next      = '0;
          pos_next      = '0;
          found_next    = 1'b0;
          pred_ok_next  = 1'b0;
          pred_next     = '0;
          succ_ok_next  = 1'b0;
          succ_next     = '0;
          full_err_next = 1'b0;
          state_next    = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx < count) begin
          state_next = S_SCAN_CMP;
        end else begin
          if (!found) begin
            pos_next = idx;
          end
          state_next = S_DECIDE;
        end
      end
      S_SCAN_CMP: begin
        if (found) begin
          succ_ok_next = 1'b1;
          succ_next    = rdata;
          state_next   = S_DECIDE;
        end else if (rdata < key_r) begin
          pred_ok_next = 1'b1;
          pred_next    = rdata;
          idx_next     = idx_inc;
          state_next   = S_SCAN_RD;
        end else if (rdata == key_r) begin
          found_next = 1'b1;
          pos_next   = idx;
          idx_next   = idx_inc;
          state_next = S_SCAN_RD;
        end else begin
          succ_ok_next = 1'b1;
          succ_next    = rdata;
          pos_next     = idx;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (cmd == CMD_INSERT && !found) begin
          if (count >= CNT_W'(CAPACITY)) begin
            full_err_next = 1'b1;
            state_next    = S_DONE;
          end else begin
            idx_next   = count;
            state_next = S_INS_RD;
          end
        end else if (cmd == CMD_REMOVE && found) begin
          idx_next   = pos;
          state_next = S_REM_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_INS_RD: begin
        if (idx > pos) begin
          mem_req.raddr = idx_dec[ADDR_W-1:0];
          state_next    = S_INS_WR;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos[ADDR_W-1:0];
          mem_req.wdata = key_r;
          count_next    = count + CNT_W'(1);
          state_next    = S_DONE;
        end
      end
      S_INS_WR: begin
        mem_req.we = 1'b1;
        idx_next   = idx_dec;
        state_next = S_INS_RD;
      end
      S_REM_RD: begin
        if (idx_inc < count) begin
          mem_req.raddr = idx_inc[ADDR_W-1:0];
          state_next    = S_REM_WR;
        end else begin
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end
      end
      S_REM_WR: begin
        mem_req.we = 1'b1;
        idx_next   = idx_inc;
        state_next = S_REM_RD;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign done      = (state == S_DONE);

  assign result.found        = found;
  assign result.pred_valid   = pred_ok;
  assign result.pred_value   = pred;
  assign result.succ_valid   = succ_ok;
  assign result.succ_value   = succ;
  assign result.stored_count = OUT_CNT_W'(count);
  assign result.full_error   = full_err;

  `SSE_CHECK(a_count_bound, count <= CNT_W'(CAPACITY))
  `SSE_IMPLY(a_write_in_shift, mem_req.we,
             state == S_INS_RD || state == S_INS_WR || state == S_REM_WR)
  `SSE_IMPLY(a_full_only_when_full, done && full_err, count == CNT_W'(CAPACITY))
  `SSE_IMPLY(a_found_pos_in_range, state == S_DECIDE && found, pos < count)
  `SSE_NEXT(a_count_stable_idle, state == S_IDLE, $stable(count))

endmodule

`default_nettype wire

@@ tb/sorted_set_engine_checker.sv @@
// checker for the sorted set engine: tracks the stored key set on every accepted request
// and compares each accepted response field by field; depends on sse_pkg
`timescale 1ns / 100ps

module sorted_set_engine_checker
  import sse_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  input  wire logic                 req_ready,
  input  wire logic [CMD_W-1:0]     command,
  input  wire key_t                 key,
  input  wire logic                 rsp_valid,
  input  wire logic                 rsp_ready,
  input  wire logic                 found,
  input  wire logic                 pred_valid,
  input  wire key_t                 pred_value,
  input  wire logic                 succ_valid,
  input  wire key_t                 succ_value,
  input  wire logic [OUT_CNT_W-1:0] stored_count,
  input  wire logic                 full_error,
  output int                        outstanding,
  output int                        failures
);

  key_t set_keys [CAPACITY];
  int   set_count = 0;
  rsp_t pending_rsps [$];
  int   fail_total = 0;
  int   pending_q = 0;

  assign outstanding = pending_q;
  assign failures    = fail_total;

  function automatic rsp_t apply_request(input logic [CMD_W-1:0] cmd, input key_t k);
    rsp_t r;
    int   pos;
    int   nxt;
    int   i;
    logic hit;
    r   = '0;
    pos = 0;
    while (pos < set_count && set_keys[pos] < k) pos++;
    hit = (pos < set_count) && (set_keys[pos] == k);
    r.found = hit;
    if (pos > 0) begin
      r.pred_valid = 1'b1;
      r.pred_value = set_keys[pos-1];
    end
    nxt = hit ? pos + 1 : pos;
    if (nxt < set_count) begin
      r.succ_valid = 1'b1;
      r.succ_value = set_keys[nxt];
    end
    if (cmd == CMD_INSERT && !hit) begin
      if (set_count >= CAPACITY) begin
        r.full_error = 1'b1;
      end else begin
        for (i = set_count; i > pos; i--) set_keys[i] = set_keys[i-1];
        set_keys[pos] = k;
        set_count++;
      end
    end else if (cmd == CMD_REMOVE && hit) begin
      for (i = pos; i + 1 < set_count; i++) set_keys[i] = set_keys[i+1];
      set_count--;
    end
    r.stored_count = set_count[OUT_CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp, act);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t exp;
    if (rst) begin
      set_count = 0;
      pending_rsps.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_rsps.size() == 0) begin
          $display("%0t ns: unexpected response, expected none, got found=%b count=%0d",
                   $time, found, stored_count);
          fail_total++;
        end else begin
          exp = pending_rsps.pop_front();
          check_field("found", exp.found, found);
          check_field("pred_valid", exp.pred_valid, pred_valid);
          check_field("pred_value", exp.pred_value, pred_value);
          check_field("succ_valid", exp.succ_valid, succ_valid);
          check_field("succ_value", exp.succ_value, succ_value);
          check_field("stored_count", exp.stored_count, stored_count);
          check_field("full_error", exp.full_error, full_error);
        end
      end
      if (req_valid && req_ready) pending_rsps.push_back(apply_request(command, key));
    end
    pending_q <= pending_rsps.size();
  end

endmodule

@@ tb/sorted_set_engine_top_tb.sv @@
// testbench top for the sorted set engine: drives bursty search/insert/remove requests,
// stalls the response side, and reports the verdict; depends on sse_pkg and the checker
`timescale 1ns / 100ps

module sorted_set_engine_top_tb;
  import sse_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam key_t KEY_MIN = 32'sh8000_0000;
  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  logic [CMD_W-1:0]     command = CMD_SEARCH;
  key_t                 key = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  logic                 found;
  logic                 pred_valid;
  key_t                 pred_value;
  logic                 succ_valid;
  key_t                 succ_value;
  logic [OUT_CNT_W-1:0] stored_count;
  logic                 full_error;
  int                   outstanding;
  int                   failures;

  int burst_left = 1;
  int stall_mode = 0;
  int stall_left = 0;

  sorted_set_engine_top u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .command(command), .key(key),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .found(found), .pred_valid(pred_valid), .pred_value(pred_value),
    .succ_valid(succ_valid), .succ_value(succ_value),
    .stored_count(stored_count), .full_error(full_error)
  );

  sorted_set_engine_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .command(command), .key(key),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .found(found), .pred_valid(pred_valid), .pred_value(pred_value),
    .succ_valid(succ_valid), .succ_value(succ_value),
    .stored_count(stored_count), .full_error(full_error),
    .outstanding(outstanding), .failures(failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // response side stall pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= $urandom_range(0, 1);
      default: rsp_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_request(input logic [CMD_W-1:0] c, input key_t k);
    int gap;
    req_valid <= 1'b1;
    command   <= c;
    key       <= k;
    do @(posedge clk); while (!req_ready);
    burst_left--;
    if (burst_left <= 0) begin
      req_valid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [CMD_W-1:0] pick_command(input int n);
    int r;
    r = $urandom_range(0, 99);
    if (n < 180 || n >= 400) begin
      // fill phase
      if (r < 85) return CMD_INSERT;
      if (r < 92) return CMD_SEARCH;
      if (r < 97) return CMD_REMOVE;
      return CMD_UNUSED;
    end else if (n < 300) begin
      if (r < 35) return CMD_INSERT;
      if (r < 65) return CMD_SEARCH;
      if (r < 95) return CMD_REMOVE;
      return CMD_UNUSED;
    end
    // drain phase
    if (r < 20) return CMD_INSERT;
    if (r < 45) return CMD_SEARCH;
    if (r < 95) return CMD_REMOVE;
    return CMD_UNUSED;
  endfunction

  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return key_t'($urandom);
    if (r == 1) begin
      case ($urandom_range(0, 5))
        0: return KEY_MIN;
        1: return KEY_MIN + 1;
        2: return KEY_MAX;
        3: return KEY_MAX - 1;
        4: return key_t'(0);
        default: return key_t'(-1);
      endcase
    end
    return key_t'(int'($urandom_range(0, 79)) - 40);
  endfunction

  initial begin
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    burst_left = $urandom_range(1, 30);

    // directed
    send_request(CMD_SEARCH, key_t'(0));
    send_request(CMD_REMOVE, key_t'(5));
    send_request(CMD_INSERT, KEY_MAX);
    send_request(CMD_INSERT, KEY_MIN);
    send_request(CMD_SEARCH, key_t'(0));
    send_request(CMD_INSERT, key_t'(0));
    send_request(CMD_INSERT, key_t'(0));
    send_request(CMD_SEARCH, key_t'(0));
    send_request(CMD_UNUSED, key_t'(0));
    send_request(CMD_REMOVE, key_t'(0));
    send_request(CMD_REMOVE, key_t'(0));
    send_request(CMD_INSERT, key_t'(-1));
    send_request(CMD_INSERT, key_t'(1));
    send_request(CMD_SEARCH, key_t'(0));
    send_request(CMD_INSERT, KEY_MIN + 1);
    send_request(CMD_SEARCH, KEY_MIN);
    send_request(CMD_SEARCH, KEY_MAX);
    send_request(CMD_UNUSED, key_t'(-1));
    send_request(CMD_REMOVE, key_t'(1));
    send_request(CMD_REMOVE, KEY_MAX);
    send_request(CMD_REMOVE, KEY_MIN);
    send_request(CMD_SEARCH, KEY_MAX - 1);
    wait_for_results();

    // random
    for (int n = 0; n < 500; n++) begin
      if (n == 180 || n == 300 || n == 400) wait_for_results();
      send_request(pick_command(n), pick_key());
    end

    wait_for_results();
    repeat (300) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("** sorted_set_engine_top: PASSED **");
    end else begin
      $display("** sorted_set_engine_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("** sorted_set_engine_top: FAILED **");
    $finish;
  end

endmodule
